// ===== hdl/lcg_keystream_xor_cipher_top_assert.svh =====
// Assertion macros for the LCG keystream XOR cipher.
// Included by the top level; no other dependencies.
`ifndef LCG_KEYSTREAM_XOR_CIPHER_TOP_ASSERT_SVH
`define LCG_KEYSTREAM_XOR_CIPHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LCGX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define LCGX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCGX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LCGX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/lcgx_pkg.sv =====
// Shared types and constants for the LCG keystream XOR cipher.
// No dependencies; used by the interfaces, the divider and the top level.
package lcgx_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;

    // Register reset values.
    localparam word_t SEED_RESET       = 32'h1337_1337;
    localparam word_t MULTIPLIER_RESET = 32'd48271;
    localparam word_t INCREMENT_RESET  = 32'd0;
    localparam word_t MODULUS_RESET    = 32'd2147483647;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_SEED       = 2'd0;
    localparam logic [1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [1:0] REG_INCREMENT  = 2'd2;
    localparam logic [1:0] REG_MODULUS    = 2'd3;

    // Request into the remainder unit.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    // Response from the remainder unit.
    typedef struct packed {
        logic  done;
        word_t remainder;
    } div_rsp_t;

endpackage

// ===== hdl/lcgx_if.sv =====
// Valid/ready stream interfaces for the cipher's input and output channels.
// Depends on lcgx_pkg for the payload types.
interface lcgx_in_if;
    logic            valid;
    logic            ready;
    lcgx_pkg::byte_t byte_in;
    logic            first;

    modport source (output valid, byte_in, first, input ready);
    modport sink (input valid, byte_in, first, output ready);
endinterface

interface lcgx_out_if;
    logic            valid;
    logic            ready;
    lcgx_pkg::byte_t byte_out;

    modport source (output valid, byte_out, input ready);
    modport sink (input valid, byte_out, output ready);
endinterface

// ===== hdl/lcgx_divu.sv =====
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on lcgx_pkg for the request and response structs.
module lcgx_divu (
    input  logic               clk,
    input  logic               rst_n,
    input  lcgx_pkg::div_req_t req,
    output lcgx_pkg::div_rsp_t rsp
);

    logic            busy_reg;
    logic            done_reg;
    logic [4:0]      cnt_reg;
    lcgx_pkg::word_t quo_reg;
    lcgx_pkg::word_t rem_reg;
    lcgx_pkg::word_t den_reg;

    logic [32:0]     trial;
    logic [32:0]     diff;
    logic            ge;
    lcgx_pkg::word_t rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[31]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[31:0] : trial[31:0];
    end

    // Control: busy for 32 steps, then a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out MSB first while the remainder builds up.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= 32'd0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/lcg_keystream_xor_cipher_top.sv =====
// Top level of the LCG keystream XOR cipher: APB registers, sequencer, key datapath.
// Depends on lcgx_pkg, lcgx_in_if/lcgx_out_if, lcgx_divu and the assertion header.
//
//   Channel      Dir   Handshake               Payload
//   in_stream    in    valid/ready             byte_in[7:0], first
//   out_stream   out   valid/ready             byte_out[7:0]
//   APB          in    psel/penable/pready     paddr[3:0], pwdata[31:0], prdata[31:0]
//
// A transaction on in_stream is accepted only in the idle state; its result is
// registered at once. The key update then runs one multiply, one add, 32 steps
// of the remainder unit and one write-back, and no new byte is accepted until it
// has finished; the divider loop is its longest part. A zero modulus skips the
// division. A stalled out_stream holds the next acceptance until its result
// leaves. Reset loads the register defaults and sets the key to the seed default.
`include "lcg_keystream_xor_cipher_top_assert.svh"

module lcg_keystream_xor_cipher_top (
    input  logic                    clk,
    input  logic                    rst_n,
    lcgx_in_if.sink                 in_stream,
    lcgx_out_if.source              out_stream,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_DIV  = 4'b1000
    } state_t;

    state_t          state_reg;
    lcgx_pkg::word_t seed_reg;
    lcgx_pkg::word_t multiplier_reg;
    lcgx_pkg::word_t increment_reg;
    lcgx_pkg::word_t modulus_reg;
    lcgx_pkg::word_t key_reg;
    lcgx_pkg::word_t prod_reg;
    logic            out_valid_reg;
    lcgx_pkg::byte_t out_byte_reg;

    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    logic            in_fire;
    lcgx_pkg::word_t key_use;
    lcgx_pkg::word_t prod_next;
    lcgx_pkg::word_t sum;
    lcgx_pkg::div_req_t div_req;
    lcgx_pkg::div_rsp_t div_rsp;

    // APB write decode; the port never waits.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= lcgx_pkg::SEED_RESET;
            multiplier_reg <= lcgx_pkg::MULTIPLIER_RESET;
            increment_reg  <= lcgx_pkg::INCREMENT_RESET;
            modulus_reg    <= lcgx_pkg::MODULUS_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lcgx_pkg::REG_SEED:       seed_reg       <= pwdata;
                lcgx_pkg::REG_MULTIPLIER: multiplier_reg <= pwdata;
                lcgx_pkg::REG_INCREMENT:  increment_reg  <= pwdata;
                lcgx_pkg::REG_MODULUS:    modulus_reg    <= pwdata;
                default:                  ;
            endcase
        end
    end

    // APB read mux.
    always_comb
    begin
        case (cfg_idx)
            lcgx_pkg::REG_SEED:       prdata = seed_reg;
            lcgx_pkg::REG_MULTIPLIER: prdata = multiplier_reg;
            lcgx_pkg::REG_INCREMENT:  prdata = increment_reg;
            lcgx_pkg::REG_MODULUS:    prdata = modulus_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    // Input acceptance: idle, and the output register free or emptying now.
    assign in_stream.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_stream.ready);
    assign in_fire         = in_stream.valid && in_stream.ready;
    assign key_use         = in_stream.first ? seed_reg : key_reg;

    // Key arithmetic: low word of the product, then the wrapped sum.
    assign prod_next = multiplier_reg * key_reg;
    assign sum       = prod_reg + increment_reg;

    // Divider request is issued from the add step when the modulus is nonzero.
    assign div_req.start    = (state_reg == ST_ADD) && (modulus_reg != 32'd0);
    assign div_req.dividend = sum;
    assign div_req.divisor  = modulus_reg;

    lcgx_divu u_divu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer and key register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg   <= lcgx_pkg::SEED_RESET;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        key_reg   <= key_use;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (modulus_reg == 32'd0)
                    begin
                        key_reg   <= sum;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        key_reg   <= div_rsp.remainder;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Product register sits between the multiplier and the adder.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
        end
    end

    // Output register: result is formed at acceptance with the key in use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_byte_reg <= in_stream.byte_in ^ key_use[7:0];
        end
    end

    assign out_stream.valid    = out_valid_reg;
    assign out_stream.byte_out = out_byte_reg;

    // Checks on the sequencer and the divider handoff.
    `LCGX_ASSERT_NEXT(a_accept_starts_mul, clk, rst_n, in_fire, (state_reg == ST_MUL) && out_valid_reg, "accepted transaction did not start the key update")
    `LCGX_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_rsp.done, state_reg == ST_DIV, "divider finished outside the divide state")
    `LCGX_ASSERT_NOW(a_div_start_nonzero, clk, rst_n, div_req.start, modulus_reg != 32'd0, "divider started with a zero modulus")

endmodule

// ===== verif/tb_lcg_keystream_xor_cipher_top.sv =====
// Self-checking testbench for the LCG keystream XOR cipher top level.
// Drives bytes and APB writes and checks every output byte against a keystream predictor.
// Depends on lcgx_pkg, lcgx_in_if/lcgx_out_if and lcg_keystream_xor_cipher_top.

// Keystream predictor and store of the output bytes still owed by the block.
class cipher_checker;
    lcgx_pkg::word_t seed;
    lcgx_pkg::word_t multiplier;
    lcgx_pkg::word_t increment;
    lcgx_pkg::word_t modulus;
    lcgx_pkg::word_t key;
    lcgx_pkg::byte_t owed_bytes[$];
    int unsigned     errors;

    function new();
        seed       = lcgx_pkg::SEED_RESET;
        multiplier = lcgx_pkg::MULTIPLIER_RESET;
        increment  = lcgx_pkg::INCREMENT_RESET;
        modulus    = lcgx_pkg::MODULUS_RESET;
        key        = lcgx_pkg::SEED_RESET;
        errors     = 0;
    endfunction

    // Track a register write; the running key is left alone.
    function void write_reg(logic [1:0] idx, lcgx_pkg::word_t value);
        case (idx)
            lcgx_pkg::REG_SEED:       seed       = value;
            lcgx_pkg::REG_MULTIPLIER: multiplier = value;
            lcgx_pkg::REG_INCREMENT:  increment  = value;
            lcgx_pkg::REG_MODULUS:    modulus    = value;
            default: ;
        endcase
    endfunction

    // The product and the sum wrap at 32 bits before the modulo; a zero modulus skips it.
    function lcgx_pkg::word_t next_key(lcgx_pkg::word_t k);
        lcgx_pkg::word_t wrapped;
        wrapped = multiplier * k + increment;
        return (modulus == 32'd0) ? wrapped : wrapped % modulus;
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(lcgx_pkg::byte_t data, logic first);
        if (first)
            key = seed;
        owed_bytes.push_back(data ^ key[7:0]);
        key = next_key(key);
    endfunction

    // Called for every accepted output transaction.
    function void check_byte(lcgx_pkg::byte_t actual);
        lcgx_pkg::byte_t want;
        if (owed_bytes.size() == 0)
        begin
            errors++;
            $error("byte_out: expected nothing, actual 0x%02h", actual);
            return;
        end
        want = owed_bytes.pop_front();
        if (actual !== want)
        begin
            errors++;
            $error("byte_out: expected 0x%02h, actual 0x%02h", want, actual);
        end
    endfunction
endclass

module tb_lcg_keystream_xor_cipher_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Settle time after the last owed byte; it outlasts the key update.
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        calm;

    cipher_checker sb;

    lcgx_in_if  in_ch ();
    lcgx_out_if out_ch ();

    lcg_keystream_xor_cipher_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output back-pressure: stall with a probability of about 17 percent unless in a calm stretch.
    always @(posedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(99) >= 17);
    end

    // Transaction monitor; reads the values that held just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_byte(in_ch.byte_in, in_ch.first);
            if (out_ch.valid && out_ch.ready)
                sb.check_byte(out_ch.byte_out);
        end
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [1:0] idx, input lcgx_pkg::word_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Present one byte, with an occasional gap before it, and wait for acceptance.
    task automatic send_byte(input lcgx_pkg::byte_t data, input logic first_flag);
        if (!calm && $urandom_range(99) < 17)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= data;
        in_ch.first   <= first_flag;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Wait until every owed byte has arrived and the key update has finished.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Main stimulus.
    initial
    begin
        lcgx_pkg::word_t v_seed;
        lcgx_pkg::word_t v_mult;
        lcgx_pkg::word_t v_incr;
        lcgx_pkg::word_t v_mod;
        int              sent;
        int              len;
        int              rand_first;

        sb            = new();
        calm          = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.byte_in = '0;
        in_ch.first   = 1'b0;
        out_ch.ready  = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // No first byte after reset: the key runs from the seed reset value.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
        wait_drained();

        // All registers at their maximum; the new seed waits for the next first byte.
        apb_write(lcgx_pkg::REG_SEED, 32'hFFFF_FFFF);
        apb_write(lcgx_pkg::REG_MULTIPLIER, 32'hFFFF_FFFF);
        apb_write(lcgx_pkg::REG_INCREMENT, 32'hFFFF_FFFF);
        apb_write(lcgx_pkg::REG_MODULUS, 32'hFFFF_FFFF);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        wait_drained();

        // All registers at zero: zero modulus skips the reduction.
        apb_write(lcgx_pkg::REG_SEED, 32'd0);
        apb_write(lcgx_pkg::REG_MULTIPLIER, 32'd0);
        apb_write(lcgx_pkg::REG_INCREMENT, 32'd0);
        apb_write(lcgx_pkg::REG_MODULUS, 32'd0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b0);
        wait_drained();

        // Zero modulus with a live generator, so the wrapped sum is the key.
        apb_write(lcgx_pkg::REG_MULTIPLIER, 32'd1103515245);
        apb_write(lcgx_pkg::REG_INCREMENT, 32'd12345);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        wait_drained();

        // Modulus of one pins the key to zero after the first byte.
        apb_write(lcgx_pkg::REG_MODULUS, 32'd1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        wait_drained();

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            calm = (phase == 2);

            case ($urandom_range(3))
                0:       v_seed = 32'd0;
                1:       v_seed = 32'hFFFF_FFFF;
                default: v_seed = $urandom;
            endcase
            case ($urandom_range(4))
                0:       v_mult = lcgx_pkg::MULTIPLIER_RESET;
                1:       v_mult = 32'hFFFF_FFFF;
                2:       v_mult = $urandom_range(0, 3);
                default: v_mult = $urandom;
            endcase
            case ($urandom_range(2))
                0:       v_incr = 32'd0;
                1:       v_incr = 32'hFFFF_FFFF;
                default: v_incr = $urandom;
            endcase
            case ($urandom_range(7))
                0:       v_mod = 32'd0;
                1:       v_mod = 32'd1;
                2:       v_mod = 32'hFFFF_FFFF;
                3:       v_mod = $urandom_range(2, 256);
                4:       v_mod = lcgx_pkg::MODULUS_RESET;
                default: v_mod = $urandom;
            endcase
            apb_write(lcgx_pkg::REG_SEED, v_seed);
            apb_write(lcgx_pkg::REG_MULTIPLIER, v_mult);
            apb_write(lcgx_pkg::REG_INCREMENT, v_incr);
            apb_write(lcgx_pkg::REG_MODULUS, v_mod);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    // A well-formed string: first byte flagged, the rest continue it.
                    len = $urandom_range(1, 24);
                    for (int j = 0; j < len; j++)
                        send_byte(lcgx_pkg::byte_t'($urandom_range(255)), j == 0);
                end
                else
                begin
                    // Noise: a few bytes with a random first flag.
                    len = $urandom_range(1, 4);
                    for (int j = 0; j < len; j++)
                    begin
                        rand_first = $urandom_range(1);
                        send_byte(lcgx_pkg::byte_t'($urandom_range(255)), rand_first[0]);
                    end
                end
                sent += len;
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.owed_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
